FILE: rtl/core/psec_pkg.sv
// Shared request codes, row kinds and lookup status type for the event counter table.
`timescale 1ns / 1ps
package psec_pkg;

    localparam logic [1:0] REQ_COUNT_A = 2'd0;
    localparam logic [1:0] REQ_COUNT_B = 2'd1;
    localparam logic [1:0] REQ_END     = 2'd2;

    localparam logic ROW_FEEDBACK = 1'b0;
    localparam logic ROW_REPORT   = 1'b1;

    typedef struct packed {
        logic hit;    // sender found among filled slots
        logic full;   // sender unknown and no slot free
        logic alloc;  // sender unknown, new slot taken
    } t_lkp_status;

endpackage

FILE: rtl/core/psec_lookup.sv
// Key registers, parallel key compare, slot encoding and allocation with fill level.
`timescale 1ns / 1ps
module psec_lookup #(
    parameter int DEPTH = 16,
    parameter int KEY_W = 22,
    parameter int IDX_W = 4,
    parameter int FILL_W = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmp_en,
    input  logic [KEY_W-1:0]       i_key,
    input  logic                   i_resolve,
    input  logic                   i_clear,
    output psec_pkg::t_lkp_status  o_status,
    output logic [IDX_W-1:0]       o_index,
    output logic [FILL_W-1:0]      o_fill
);
    import psec_pkg::*;

    logic [KEY_W-1:0]  r_key [DEPTH];
    logic [KEY_W-1:0]  r_key_q;
    logic [DEPTH-1:0]  r_hit;
    logic [DEPTH-1:0]  n_hit;
    logic [FILL_W-1:0] r_fill;
    logic [IDX_W-1:0]  hit_idx;
    t_lkp_status       status;

    // compare against every filled slot; keys are unique so at most one hits
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_hit[i] = (FILL_W'(i) < r_fill) && (r_key[i] == i_key);
        end
    end

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_idx = hit_idx | (r_hit[i] ? IDX_W'(i) : '0);
        end
    end

    always_comb begin
        status.hit   = |r_hit;
        status.full  = !status.hit && (r_fill == FILL_W'(DEPTH));
        status.alloc = !status.hit && !status.full;
    end

    assign o_status = status;
    assign o_index  = status.hit ? hit_idx : (status.alloc ? r_fill[IDX_W-1:0] : '0);
    assign o_fill   = r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= '0;
            r_fill <= '0;
        end else begin
            if (i_cmp_en) begin
                r_hit <= n_hit;
            end
            if (i_clear) begin
                r_fill <= '0;
            end else if (i_resolve && status.alloc) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_key_q <= i_key;
        end
        if (i_resolve && status.alloc) begin
            r_key[r_fill[IDX_W-1:0]] <= r_key_q;
        end
    end

endmodule

FILE: rtl/core/per_sender_event_counter_table.sv
// Top level of the per-sender event counter table: sequencer, count memory, output register.
`timescale 1ns / 1ps
// Each accepted request (count A, count B, or end) looks its sender up among the
// filled slots, allocating a zeroed slot for an unknown sender while one is free.
// It returns one feedback row with the slot index and counts after the update,
// or table_full set (index and counts zero, event dropped) when no slot is free.
// An end request then streams one report row per filled slot, in slot order,
// and empties the table; last_row marks the final row caused by a request.
// Steps: a count request is compared in the cycle it is accepted, then the
// lookup state encodes the hit, allocates and reads the memory, then the update
// state does the read-modify-write of the count memory and loads the feedback
// row into the output register; the next request is accepted in the cycle the
// feedback row is loaded, if the output register has room. An end request adds,
// per filled slot, a report read (memory read) and an emit (output load) step.
// Keys live in registers for the parallel compare; keys and counts also live
// in one synchronous memory, one row per slot, with a registered read. A full
// output register stalls the sequencer without losing data.
module per_sender_event_counter_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_WIDTH   = 22,
    parameter int COUNT_WIDTH = 32,
    parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_req_type,
    input  logic [KEY_WIDTH-1:0]   i_sender_id,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_row_kind,
    output logic [IDX_W-1:0]       o_entry_index,
    output logic                   o_table_full,
    output logic [KEY_WIDTH-1:0]   o_key_out,
    output logic [COUNT_WIDTH-1:0] o_count_a,
    output logic [COUNT_WIDTH-1:0] o_count_b,
    output logic                   o_last_row
);
    import psec_pkg::*;

    localparam int FILL_W  = IDX_W + 1;
    localparam int ROW_W   = KEY_WIDTH + 2 * COUNT_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;  // encode hit, allocate, read counts
    localparam logic [2:0] S_UPD  = 3'd2;  // modify, write back, feedback row
    localparam logic [2:0] S_RD   = 3'd3;  // report: read slot
    localparam logic [2:0] S_EMIT = 3'd4;  // report: load row

    logic [2:0]  r_state, n_state;
    logic [1:0]  r_kind;
    logic [KEY_WIDTH-1:0] r_key;
    logic [IDX_W-1:0]     r_idx;
    logic        r_full;
    logic        r_alloc;
    logic [IDX_W-1:0]     r_ptr;

    // count memory: {key, count_a, count_b} per slot
    logic [ROW_W-1:0] r_mem [TABLE_DEPTH];
    logic [ROW_W-1:0] r_rd;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic             mem_we;

    // output register
    logic        r_ovalid;
    logic        r_o_kind;
    logic [IDX_W-1:0]       r_o_idx;
    logic        r_o_full;
    logic [KEY_WIDTH-1:0]   r_o_key;
    logic [COUNT_WIDTH-1:0] r_o_a;
    logic [COUNT_WIDTH-1:0] r_o_b;
    logic        r_o_last;

    t_lkp_status       lkp_status;
    logic [IDX_W-1:0]  lkp_index;
    logic [FILL_W-1:0] lkp_fill;

    logic        in_accept;
    logic        out_free;
    logic        load_fb;
    logic        load_rpt;
    logic        rpt_last;
    logic        rpt_clear;
    logic [COUNT_WIDTH-1:0] cur_a, cur_b, new_a, new_b;

    assign out_free  = !r_ovalid || i_ready;
    assign o_ready   = (r_state == S_IDLE) ||
                       ((r_state == S_UPD) && out_free && (r_kind != REQ_END));
    assign in_accept = i_valid && o_ready;

    psec_lookup #(
        .DEPTH  (TABLE_DEPTH),
        .KEY_W  (KEY_WIDTH),
        .IDX_W  (IDX_W),
        .FILL_W (FILL_W)
    ) u_lookup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmp_en  (in_accept),
        .i_key     (i_sender_id),
        .i_resolve (r_state == S_LOOK),
        .i_clear   (rpt_clear),
        .o_status  (lkp_status),
        .o_index   (lkp_index),
        .o_fill    (lkp_fill)
    );

    // read-modify-write of the counts; a fresh slot starts from zero
    always_comb begin
        cur_a = r_alloc ? '0 : r_rd[2*COUNT_WIDTH-1:COUNT_WIDTH];
        cur_b = r_alloc ? '0 : r_rd[COUNT_WIDTH-1:0];
        new_a = cur_a;
        new_b = cur_b;
        if (r_kind == REQ_COUNT_A && cur_a != '1) begin
            new_a = cur_a + COUNT_WIDTH'(1);
        end
        if (r_kind == REQ_COUNT_B && cur_b != '1) begin
            new_b = cur_b + COUNT_WIDTH'(1);
        end
    end

    assign load_fb   = (r_state == S_UPD) && out_free;
    assign load_rpt  = (r_state == S_EMIT) && out_free;
    assign rpt_last  = (({1'b0, r_ptr} + FILL_W'(1)) == lkp_fill);
    assign rpt_clear = load_rpt && rpt_last;

    // one read port, shared by the lookup read and the report sweep
    assign mem_rd_en   = (r_state == S_LOOK) || (r_state == S_RD);
    assign mem_rd_addr = (r_state == S_LOOK) ? lkp_index : r_ptr;
    assign mem_we      = load_fb && !r_full;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= {r_key, new_a, new_b};
        end
        if (mem_rd_en) begin
            r_rd <= r_mem[mem_rd_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_LOOK;
            end
            S_LOOK: n_state = S_UPD;
            S_UPD: begin
                if (load_fb) begin
                    if (r_kind == REQ_END) n_state = S_RD;
                    else if (in_accept)    n_state = S_LOOK;
                    else                   n_state = S_IDLE;
                end
            end
            S_RD: n_state = S_EMIT;
            S_EMIT: begin
                if (load_rpt) n_state = rpt_last ? S_IDLE : S_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_fb || load_rpt) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind <= i_req_type;
            r_key  <= i_sender_id;
        end
        if (r_state == S_LOOK) begin
            r_idx   <= lkp_index;
            r_full  <= lkp_status.full;
            r_alloc <= lkp_status.alloc;
        end
        if (load_fb) begin
            r_ptr <= '0;
        end else if (load_rpt) begin
            r_ptr <= r_ptr + IDX_W'(1);
        end
        if (load_fb) begin
            r_o_kind <= ROW_FEEDBACK;
            r_o_idx  <= r_idx;
            r_o_full <= r_full;
            r_o_key  <= r_key;
            r_o_a    <= r_full ? '0 : new_a;
            r_o_b    <= r_full ? '0 : new_b;
            r_o_last <= (r_kind != REQ_END) || (lkp_fill == '0);
        end else if (load_rpt) begin
            r_o_kind <= ROW_REPORT;
            r_o_idx  <= r_ptr;
            r_o_full <= 1'b0;
            r_o_key  <= r_rd[ROW_W-1:2*COUNT_WIDTH];
            r_o_a    <= r_rd[2*COUNT_WIDTH-1:COUNT_WIDTH];
            r_o_b    <= r_rd[COUNT_WIDTH-1:0];
            r_o_last <= rpt_last;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_row_kind    = r_o_kind;
    assign o_entry_index = r_o_idx;
    assign o_table_full  = r_o_full;
    assign o_key_out     = r_o_key;
    assign o_count_a     = r_o_a;
    assign o_count_b     = r_o_b;
    assign o_last_row    = r_o_last;

    // an accepted request always goes to the lookup step
    a_accept_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_LOOK))
        else $error("accepted request did not enter lookup");

    // a dropped event only happens with every slot filled
    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && r_full) |-> (lkp_fill == FILL_W'(TABLE_DEPTH)))
        else $error("table_full with a free slot");

    // fill level never passes the table depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lkp_fill <= FILL_W'(TABLE_DEPTH)))
        else $error("fill level beyond table depth");

    // the final report row empties the table
    a_report_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rpt_clear |=> ((lkp_fill == '0) && (r_state == S_IDLE)))
        else $error("table not emptied after report");

endmodule

FILE: bench/per_sender_event_counter_table_tb.sv
// Self-checking testbench for the per-sender event counter table.
`timescale 1ns / 1ps
// A directed opener covers these cases:
//   - field extremes and every request kind, the spare code among them
//   - an end request on an empty table, which allocates and then reports itself
//   - a table filled to the last slot
//   - count and end requests from an unknown sender once the table is full
// Random sessions of count requests over a sender pool of varying size follow.
// Each session closes with an end request, and some sessions run long enough
// to overflow the table. Sparse noise (random ids, the spare code, end requests) is mixed in.
// A scoreboard object mirrors the table and queues the rows each accepted
// request must produce. Rows are checked in order, field by field.
// Count saturation needs 2^32 - 1 bumps and cannot be reached in a run. The
// predictor still models it.
module per_sender_event_counter_table_tb;
    import psec_pkg::*;

    localparam int DEPTH = 16;
    localparam int KEY_W = 22;
    localparam int CNT_W = 32;
    localparam int IDX_W = 4;
    localparam logic [1:0] REQ_SPARE = 2'd3;   // unused code: lookup and feedback only
    localparam int N_RANDOM     = 125;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_CYCLES  = 300;         // long receiver hold-off
    localparam int DRAIN_CYCLES = 80;          // well past the longest report sweep
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic             row_kind;
        logic [IDX_W-1:0] entry_index;
        logic             table_full;
        logic [KEY_W-1:0] key_out;
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_b;
        logic             last_row;
    } counter_row_t;

    // Mirror of the table plus the rows still owed by the block.
    class counter_table_scoreboard;
        logic [KEY_W-1:0] slot_key [DEPTH];
        logic [CNT_W-1:0] slot_a   [DEPTH];
        logic [CNT_W-1:0] slot_b   [DEPTH];
        int               fill;
        counter_row_t     rows_due[$];
        int errors;
        int rows_checked;
        int full_answers;
        int report_rows;
        int end_requests;

        function new();
            fill = 0;
            errors = 0;
            rows_checked = 0;
            full_answers = 0;
            report_rows = 0;
            end_requests = 0;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        // Lookup, allocation, count update, then feedback and report rows.
        function void note_request(logic [1:0] kind, logic [KEY_W-1:0] id);
            int           idx;
            bit           hit;
            bit           full;
            counter_row_t row;
            idx = 0;
            hit = 0;
            full = 0;
            for (int i = 0; i < fill; i++) begin
                if (!hit && slot_key[i] == id) begin
                    idx = i;
                    hit = 1;
                end
            end
            if (!hit) begin
                if (fill < DEPTH) begin
                    idx = fill;
                    slot_key[idx] = id;
                    slot_a[idx] = '0;
                    slot_b[idx] = '0;
                    fill++;
                end else begin
                    full = 1;   // unknown sender, no slot: event dropped
                end
            end
            if (!full) begin
                if (kind == REQ_COUNT_A && slot_a[idx] != '1) begin
                    slot_a[idx] = slot_a[idx] + 1'b1;
                end else if (kind == REQ_COUNT_B && slot_b[idx] != '1) begin
                    slot_b[idx] = slot_b[idx] + 1'b1;
                end
            end
            if (full) full_answers++;
            row.row_kind    = ROW_FEEDBACK;
            row.entry_index = full ? '0 : IDX_W'(idx);
            row.table_full  = full;
            row.key_out     = id;
            row.count_a     = full ? '0 : slot_a[idx];
            row.count_b     = full ? '0 : slot_b[idx];
            row.last_row    = (kind != REQ_END) || (fill == 0);
            rows_due.push_back(row);
            if (kind == REQ_END) begin
                end_requests++;
                for (int i = 0; i < fill; i++) begin
                    row.row_kind    = ROW_REPORT;
                    row.entry_index = IDX_W'(i);
                    row.table_full  = 1'b0;
                    row.key_out     = slot_key[i];
                    row.count_a     = slot_a[i];
                    row.count_b     = slot_b[i];
                    row.last_row    = (i == fill - 1);
                    rows_due.push_back(row);
                end
                report_rows += fill;
                fill = 0;
            end
        endfunction

        function void flag(string field, logic [63:0] want, logic [63:0] got);
            errors++;
            if (errors <= 10) begin
                $display("row %0d: %s expected %h, got %h", rows_checked, field, want, got);
            end
        endfunction

        function void check_row(counter_row_t got);
            counter_row_t want;
            if (rows_due.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("row with nothing pending: kind %0d index %0d key %h",
                             got.row_kind, got.entry_index, got.key_out);
                end
                return;
            end
            want = rows_due.pop_front();
            if (got.row_kind !== want.row_kind)
                flag("row_kind", want.row_kind, got.row_kind);
            if (got.entry_index !== want.entry_index)
                flag("entry_index", want.entry_index, got.entry_index);
            if (got.table_full !== want.table_full)
                flag("table_full", want.table_full, got.table_full);
            if (got.key_out !== want.key_out)
                flag("key_out", want.key_out, got.key_out);
            if (got.count_a !== want.count_a)
                flag("count_a", want.count_a, got.count_a);
            if (got.count_b !== want.count_b)
                flag("count_b", want.count_b, got.count_b);
            if (got.last_row !== want.last_row)
                flag("last_row", want.last_row, got.last_row);
            rows_checked++;
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    logic [1:0]       i_req_type;
    logic [KEY_W-1:0] i_sender_id;
    logic             o_valid;
    logic             i_ready;
    logic             o_row_kind;
    logic [IDX_W-1:0] o_entry_index;
    logic             o_table_full;
    logic [KEY_W-1:0] o_key_out;
    logic [CNT_W-1:0] o_count_a;
    logic [CNT_W-1:0] o_count_b;
    logic             o_last_row;

    counter_table_scoreboard sb = new();

    bit quiet   = 0;   // no idling on either side while set
    bit hold_go = 0;   // asks the receiver for one long hold-off
    int n_sent  = 0;
    int cycle_count = 0;
    logic [KEY_W-1:0] sender_pool [POOL_SIZE];

    per_sender_event_counter_table #(
        .TABLE_DEPTH (DEPTH),
        .KEY_WIDTH   (KEY_W),
        .COUNT_WIDTH (CNT_W)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_sender_id   (i_sender_id),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_row_kind    (o_row_kind),
        .o_entry_index (o_entry_index),
        .o_table_full  (o_table_full),
        .o_key_out     (o_key_out),
        .o_count_a     (o_count_a),
        .o_count_b     (o_count_b),
        .o_last_row    (o_last_row)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still pending",
                     cycle_count, sb.pending());
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, quiet stretches, one long hold-off on request.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        i_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_left = HOLD_CYCLES;
                hold_go = 0;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (quiet) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 10);
            end
        end
    end

    // Rows are taken at the rising edge where valid and ready meet.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_row('{o_row_kind, o_entry_index, o_table_full, o_key_out,
                           o_count_a, o_count_b, o_last_row});
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance,
    // with valid still high so a following request can go back to back.
    task automatic send_request(input logic [1:0] kind, input logic [KEY_W-1:0] id);
        i_valid     <= 1'b1;
        i_req_type  <= kind;
        i_sender_id <= id;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(kind, id);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Sender idles in about one request slot of ten.
    task automatic sender_gap();
        int gap;
        if (!quiet && $urandom_range(0, 99) < 10) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    initial begin : stimulus
        int               n_random;
        int               session_len;
        int               pool_n;
        int               r;
        logic [1:0]       kind;
        logic [KEY_W-1:0] id;
        bit               hold_done;
        bit               pause_done;

        hold_done   = 0;
        pause_done  = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req_type  = REQ_COUNT_A;
        i_sender_id = '0;
        sender_pool[0] = '0;
        sender_pool[1] = '1;
        sender_pool[2] = 22'h2AAAAA;
        sender_pool[3] = 22'h155555;
        for (int i = 4; i < POOL_SIZE; i++) sender_pool[i] = KEY_W'($urandom);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: both counts, a hit, key extremes, spare code, end with hits.
        send_request(REQ_COUNT_A, 22'h000000);
        send_request(REQ_COUNT_B, 22'h000000);
        send_request(REQ_COUNT_A, 22'h000000);
        sender_gap();
        send_request(REQ_COUNT_A, 22'h3FFFFF);
        send_request(REQ_COUNT_B, 22'h2AAAAA);
        send_request(REQ_SPARE,   22'h155555);
        send_request(REQ_END,     22'h000000);
        // End on an empty table: allocates, then reports its own slot.
        send_request(REQ_END,     22'h3FFFFF);
        // Fill all 16 slots.
        for (int i = 0; i < DEPTH; i++) begin
            sender_gap();
            send_request((i % 2) ? REQ_COUNT_B : REQ_COUNT_A, KEY_W'(32'h1000 * (i + 1) + i));
        end
        // Table full: dropped count, then end with a full feedback and 16 report rows.
        send_request(REQ_COUNT_A, 22'h3ABCDE);
        send_request(REQ_END,     22'h000777);

        // Random sessions: counts over a pool, closed by an end request.
        n_random = 0;
        while (n_random < N_RANDOM) begin
            session_len = ($urandom_range(0, 3) == 0) ? $urandom_range(18, 40)
                                                      : $urandom_range(2, 14);
            pool_n = $urandom_range(2, POOL_SIZE);
            for (int k = 0; k < session_len; k++) begin
                r = $urandom_range(0, 99);
                id = (r < 8) ? KEY_W'($urandom) : sender_pool[$urandom_range(0, pool_n - 1)];
                r = $urandom_range(0, 99);
                kind = (r < 48) ? REQ_COUNT_A :
                       (r < 92) ? REQ_COUNT_B :
                       (r < 96) ? REQ_SPARE   : REQ_END;
                if (n_random >= 20 && !hold_done) begin
                    hold_done = 1;
                    hold_go = 1;   // block fills and stalls its input
                end
                if (n_random >= 60 && !pause_done) quiet = 1;
                if (n_random >= 100 && !pause_done) begin
                    // Pause until every owed row has come out.
                    pause_done = 1;
                    quiet = 0;
                    i_valid <= 1'b0;
                    while (sb.pending() != 0) @(posedge i_clk);
                    @(negedge i_clk);
                end
                sender_gap();
                send_request(kind, id);
                n_random++;
            end
            sender_gap();
            send_request(REQ_END, sender_pool[$urandom_range(0, pool_n - 1)]);
            n_random++;
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests sent (%0d end), %0d rows checked: %0d report rows, %0d full",
                 n_sent, sb.end_requests, sb.rows_checked, sb.report_rows, sb.full_answers);
        $display("%0d mismatches", sb.errors);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/psec_pkg.sv
rtl/core/psec_lookup.sv
rtl/core/per_sender_event_counter_table.sv
bench/per_sender_event_counter_table_tb.sv
